// ----- hdl/chpio_pkg.sv -----
// ----------------------------------------------------------------------------
// chpio_pkg
// Shared codes, register offsets, types and helpers for the high I/O page.
// ----------------------------------------------------------------------------
package chpio_pkg;

  // event codes carried in the request kind
  localparam logic [3:0] CMD_READ    = 4'd0;
  localparam logic [3:0] CMD_WRITE   = 4'd1;
  localparam logic [3:0] CMD_DIV     = 4'd2;
  localparam logic [3:0] CMD_TIMA    = 4'd3;
  localparam logic [3:0] CMD_DISPLAY = 4'd4;
  localparam logic [3:0] CMD_BUTTON  = 4'd5;
  localparam logic [3:0] CMD_SET_IRQ = 4'd6;
  localparam logic [3:0] CMD_CLR_IRQ = 4'd7;
  localparam logic [3:0] CMD_SYNC    = 4'd8;

  // register offsets within the page
  localparam logic [7:0] OFS_P1   = 8'h00;
  localparam logic [7:0] OFS_SB   = 8'h01;
  localparam logic [7:0] OFS_SC   = 8'h02;
  localparam logic [7:0] OFS_DIV  = 8'h04;
  localparam logic [7:0] OFS_TIMA = 8'h05;
  localparam logic [7:0] OFS_TMA  = 8'h06;
  localparam logic [7:0] OFS_TAC  = 8'h07;
  localparam logic [7:0] OFS_IF   = 8'h0F;
  localparam logic [7:0] OFS_STAT = 8'h41;
  localparam logic [7:0] OFS_LY   = 8'h44;
  localparam logic [7:0] OFS_LYC  = 8'h45;
  localparam logic [7:0] OFS_DMA  = 8'h46;
  localparam logic [7:0] OFS_IE   = 8'hFF;

  localparam logic [7:0] IO_RESET     = 8'hFF;
  localparam logic [7:0] SERIAL_START = 8'h81;
  localparam logic [7:0] VBLANK_LINE  = 8'd144;
  localparam logic [7:0] IF_READ_ONES = 8'hE0;
  localparam logic [7:0] STAT_RD_ONES = 8'h80;
  localparam logic [7:0] STAT_WR_MASK = 8'hF8;

  localparam int unsigned PAGE_DEPTH = 256;
  localparam int unsigned IO_DEPTH   = 128;

  // access to the page ram
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] addr;
    logic [7:0] wdata;
  } mem_req_t;

  // one result item
  typedef struct packed {
    logic [7:0]  serial_byte;
    logic        serial_valid;
    logic [15:0] dma_source;
    logic        dma_start;
    logic        div_reset_flag;
    logic [2:0]  timer_control;
    logic [7:0]  active_interrupts;
    logic [7:0]  read_data;
  } result_t;

  // level of the lcd status interrupt line
  function automatic logic stat_line(input logic [7:0] stat);
    logic mode_hit;
    logic lyc_hit;
    case (stat[1:0])
      2'd0:    mode_hit = stat[3];
      2'd1:    mode_hit = stat[4];
      2'd2:    mode_hit = stat[5];
      default: mode_hit = 1'b0;
    endcase
    lyc_hit = stat[2] & stat[6];
    return mode_hit | lyc_hit;
  endfunction

endpackage

// ----- hdl/chpio_page_ram.sv -----
// ----------------------------------------------------------------------------
// chpio_page_ram
// Page ram for plain i/o bytes and high ram, one access a cycle, registered
// read; i/o bytes that were never written read as the reset value.
// ----------------------------------------------------------------------------
module chpio_page_ram (
  input  logic                clk,
  input  logic                rst,
  input  chpio_pkg::mem_req_t req,
  output logic [7:0]          rdata
);

  logic [7:0] mem [chpio_pkg::PAGE_DEPTH];
  logic [chpio_pkg::IO_DEPTH-1:0] io_valid;
  logic [7:0] mem_q;
  logic       hit_q;

  // storage array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.addr];
    end
  end

  // written marks for the i/o half, high ram carries none
  always_ff @(posedge clk) begin
    if (rst) begin
      io_valid <= '0;
      hit_q    <= 1'b0;
    end else begin
      if (req.wr_en && !req.addr[7]) begin
        io_valid[req.addr[6:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_q <= req.addr[7] | io_valid[req.addr[6:0]];
      end
    end
  end

  assign rdata = hit_q ? mem_q : chpio_pkg::IO_RESET;

endmodule

// ----- hdl/console_high_page_io_registers.sv -----
// ----------------------------------------------------------------------------
// console_high_page_io_registers
// I/O register page, high ram and interrupt enable of a handheld console.
// ----------------------------------------------------------------------------
// One request on the slave side is one event: s_tuser carries the command,
// s_tdata the address offset, write byte, display line and mode, button and
// interrupt number. Every request gives exactly one result on the master
// side: read byte, pending interrupts, timer control, divider reset flag,
// dma start and source, serial send and byte.
// Timer, divider, interrupt, lcd, joypad and serial registers sit in flops;
// the remaining i/o bytes and high ram live in a 256 x 8 page ram whose
// read is registered.
// A result passes through the ram read stage and then the output register
// before it is presented on the master side.
// Throughput: one request per cycle, bounded by the single ram port.
// When the receiver stalls, one result waits in the output register and one
// more in the read stage; s_tready drops only when both are full.
// Reset: i/o bytes read 0xFF, interrupt enable, buttons and the divider
// flag are zero; written marks clear at once, so no clearing pass is run.
// High ram holds whatever it powers up with until it is written.
// ----------------------------------------------------------------------------
module console_high_page_io_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // page_offset[7:0], write_data[15:8], line_number[23:16],
  // display_mode[25:24], button_index[28:26], button_pressed[29],
  // irq_number[32:30], zero fill [39:33]
  input  logic [39:0] s_tdata,
  // command[3:0]
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], active_interrupts[15:8], timer_control[18:16],
  // div_reset_flag[19], dma_start[20], dma_source[36:21], serial_valid[37],
  // serial_byte[45:38], zero fill [47:46]
  output logic [47:0] m_tdata
);

  // request fields
  logic [3:0] command;
  logic [7:0] page_offset;
  logic [7:0] write_data;
  logic [7:0] line_number;
  logic [1:0] display_mode;
  logic [2:0] button_index;
  logic       button_pressed;
  logic [2:0] irq_number;

  assign command        = s_tuser;
  assign page_offset    = s_tdata[7:0];
  assign write_data     = s_tdata[15:8];
  assign line_number    = s_tdata[23:16];
  assign display_mode   = s_tdata[25:24];
  assign button_index   = s_tdata[28:26];
  assign button_pressed = s_tdata[29];
  assign irq_number     = s_tdata[32:30];

  // register file in flops
  logic [3:0] p1_hi, p1_hi_next;
  logic [7:0] sb, sb_next;
  logic [7:0] sc, sc_next;
  logic [7:0] div_cnt, div_cnt_next;
  logic [7:0] tima, tima_next;
  logic [7:0] tma, tma_next;
  logic [7:0] tac, tac_next;
  logic [7:0] if_reg, if_reg_next;
  logic [7:0] stat, stat_next;
  logic [7:0] ly, ly_next;
  logic [7:0] lyc, lyc_next;
  logic [7:0] ie, ie_next;
  logic [7:0] buttons, buttons_next;
  logic       div_pend, div_pend_next;

  // pipeline
  logic                accept;
  logic                a_valid;
  logic                a_use_mem;
  chpio_pkg::result_t  a_res;
  logic                a_move;
  logic                o_valid;
  chpio_pkg::result_t  o_res;
  chpio_pkg::result_t  res;
  logic                use_mem;
  chpio_pkg::mem_req_t mem_req;
  logic [7:0]          mem_rdata;
  logic [3:0]          pad_lo;
  logic [3:0]          pad_hi;
  logic                stat_before;

  assign a_move   = a_valid && (!o_valid || m_tready);
  assign s_tready = !a_valid || !o_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // event decode and next register values
  always_comb begin
    p1_hi_next    = p1_hi;
    sb_next       = sb;
    sc_next       = sc;
    div_cnt_next  = div_cnt;
    tima_next     = tima;
    tma_next      = tma;
    tac_next      = tac;
    if_reg_next   = if_reg;
    stat_next     = stat;
    ly_next       = ly;
    lyc_next      = lyc;
    ie_next       = ie;
    buttons_next  = buttons;
    div_pend_next = div_pend;
    res           = '0;
    use_mem       = 1'b0;
    mem_req.rd_en = accept;
    mem_req.wr_en = 1'b0;
    mem_req.addr  = page_offset;
    mem_req.wdata = write_data;
    pad_lo        = p1_hi[0] ? 4'h0 : buttons[3:0];
    pad_hi        = p1_hi[1] ? 4'h0 : buttons[7:4];
    stat_before   = chpio_pkg::stat_line(stat);

    case (command)
      chpio_pkg::CMD_READ: begin
        if (page_offset == chpio_pkg::OFS_IE) begin
          res.read_data = ie;
        end else if (page_offset[7]) begin
          use_mem = 1'b1;
        end else begin
          case (page_offset)
            chpio_pkg::OFS_P1:   res.read_data = {p1_hi, ~(pad_lo | pad_hi)};
            chpio_pkg::OFS_SB:   res.read_data = sb;
            chpio_pkg::OFS_SC:   res.read_data = sc;
            chpio_pkg::OFS_DIV:  res.read_data = div_cnt;
            chpio_pkg::OFS_TIMA: res.read_data = tima;
            chpio_pkg::OFS_TMA:  res.read_data = tma;
            chpio_pkg::OFS_TAC:  res.read_data = tac;
            chpio_pkg::OFS_IF:   res.read_data = if_reg | chpio_pkg::IF_READ_ONES;
            chpio_pkg::OFS_STAT: res.read_data = stat | chpio_pkg::STAT_RD_ONES;
            chpio_pkg::OFS_LY:   res.read_data = ly;
            chpio_pkg::OFS_LYC:  res.read_data = lyc;
            default:             use_mem = 1'b1;
          endcase
        end
      end
      chpio_pkg::CMD_WRITE: begin
        if (page_offset == chpio_pkg::OFS_IE) begin
          ie_next = write_data;
        end else if (page_offset[7]) begin
          mem_req.wr_en = accept;
        end else begin
          case (page_offset)
            chpio_pkg::OFS_P1:   p1_hi_next = write_data[7:4];
            chpio_pkg::OFS_SB:   sb_next = write_data;
            chpio_pkg::OFS_SC: begin
              if (write_data == chpio_pkg::SERIAL_START) begin
                res.serial_valid = 1'b1;
                res.serial_byte  = sb;
                sc_next          = 8'h00;
              end
            end
            chpio_pkg::OFS_DIV: begin
              div_cnt_next  = 8'h00;
              div_pend_next = 1'b1;
            end
            chpio_pkg::OFS_TIMA: tima_next = write_data;
            chpio_pkg::OFS_TMA:  tma_next = write_data;
            chpio_pkg::OFS_TAC:  tac_next = write_data;
            chpio_pkg::OFS_IF:   if_reg_next = write_data;
            chpio_pkg::OFS_STAT: begin
              stat_next = (stat & ~chpio_pkg::STAT_WR_MASK)
                        | (write_data & chpio_pkg::STAT_WR_MASK);
            end
            chpio_pkg::OFS_LY:   ly_next = ly;
            chpio_pkg::OFS_LYC:  lyc_next = write_data;
            chpio_pkg::OFS_DMA: begin
              res.dma_start  = 1'b1;
              res.dma_source = {write_data, 8'h00};
            end
            default:             mem_req.wr_en = accept;
          endcase
        end
      end
      chpio_pkg::CMD_DIV: begin
        div_cnt_next = div_cnt + 8'd1;
      end
      chpio_pkg::CMD_TIMA: begin
        // overflow reloads from the modulo and raises the timer interrupt
        if (tima == 8'hFF) begin
          tima_next      = tma;
          if_reg_next[2] = 1'b1;
        end else begin
          tima_next = tima + 8'd1;
        end
      end
      chpio_pkg::CMD_DISPLAY: begin
        ly_next   = line_number;
        stat_next = {stat[7:3], (line_number == lyc), display_mode};
        if (ly < chpio_pkg::VBLANK_LINE && line_number >= chpio_pkg::VBLANK_LINE) begin
          if_reg_next[0] = 1'b1;
        end
        if (!stat_before && chpio_pkg::stat_line(stat_next)) begin
          if_reg_next[1] = 1'b1;
        end
      end
      chpio_pkg::CMD_BUTTON: begin
        buttons_next[button_index] = button_pressed;
      end
      chpio_pkg::CMD_SET_IRQ: begin
        if_reg_next[irq_number] = 1'b1;
      end
      chpio_pkg::CMD_CLR_IRQ: begin
        if_reg_next[irq_number] = 1'b0;
      end
      chpio_pkg::CMD_SYNC: begin
        res.div_reset_flag = div_pend;
        div_pend_next      = 1'b0;
      end
      default: begin
        res.read_data = 8'h00;
      end
    endcase

    res.active_interrupts = ie_next & if_reg_next;
    res.timer_control     = tac_next[2:0];
  end

  chpio_page_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // register file update
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_hi    <= 4'hF;
      sb       <= chpio_pkg::IO_RESET;
      sc       <= chpio_pkg::IO_RESET;
      div_cnt  <= chpio_pkg::IO_RESET;
      tima     <= chpio_pkg::IO_RESET;
      tma      <= chpio_pkg::IO_RESET;
      tac      <= chpio_pkg::IO_RESET;
      if_reg   <= chpio_pkg::IO_RESET;
      stat     <= chpio_pkg::IO_RESET;
      ly       <= chpio_pkg::IO_RESET;
      lyc      <= chpio_pkg::IO_RESET;
      ie       <= 8'h00;
      buttons  <= 8'h00;
      div_pend <= 1'b0;
    end else if (accept) begin
      p1_hi    <= p1_hi_next;
      sb       <= sb_next;
      sc       <= sc_next;
      div_cnt  <= div_cnt_next;
      tima     <= tima_next;
      tma      <= tma_next;
      tac      <= tac_next;
      if_reg   <= if_reg_next;
      stat     <= stat_next;
      ly       <= ly_next;
      lyc      <= lyc_next;
      ie       <= ie_next;
      buttons  <= buttons_next;
      div_pend <= div_pend_next;
    end
  end

  // read stage and output register valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // payload of both stages, ram data merged on the way out
  always_ff @(posedge clk) begin
    if (accept) begin
      a_res     <= res;
      a_use_mem <= use_mem;
    end
    if (a_move) begin
      o_res           <= a_res;
      o_res.read_data <= a_use_mem ? mem_rdata : a_res.read_data;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {2'b00, o_res};

`ifndef NO_ASSERTIONS
  // back pressure only when both result slots are occupied
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (a_valid && o_valid))
    else $error("request refused with a free result slot");

  // a waiting read stage always reaches an empty output register
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && !o_valid) |=> o_valid)
    else $error("read stage did not advance");

  // a divider write leaves the reset flag pending
  assert property (@(posedge clk) disable iff (rst)
    (accept && command == chpio_pkg::CMD_WRITE && page_offset == chpio_pkg::OFS_DIV)
    |=> div_pend)
    else $error("divider reset flag not set");

  // timer overflow raises the timer interrupt flag
  assert property (@(posedge clk) disable iff (rst)
    (accept && command == chpio_pkg::CMD_TIMA && tima == 8'hFF) |=> if_reg[2])
    else $error("timer overflow without interrupt flag");
`endif

endmodule
